// ===== sv/vtpd_pkg.sv =====
// Package for the vertex transform and perspective divide block.
// Holds widths, register indexes and shared types; depends on nothing.
package vtpd_pkg;
   localparam int DataWidth = 32;
   localparam int CsrWidth = 64;
   localparam int CsrAddrWidth = 3;
   localparam int DefFracBits = 16;
   localparam int SumWidth = 32;

   typedef enum logic [CsrAddrWidth-1:0] {
      REG_ROW0_COLS01 = 3'd0,
      REG_ROW0_COLS23 = 3'd1,
      REG_ROW1_COLS01 = 3'd2,
      REG_ROW1_COLS23 = 3'd3,
      REG_ROW2_COLS01 = 3'd4,
      REG_ROW2_COLS23 = 3'd5,
      REG_ROW3_COLS01 = 3'd6,
      REG_ROW3_COLS23 = 3'd7
   } csr_index_type;

   // Saturate a 36-bit sum to signed 32 bits.
   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      logic signed [31:0] r;
      begin
         if (v > 36'sh07FFFFFFF) r = 32'sh7FFFFFFF;
         else if (v < -36'sh080000000) r = -32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction
endpackage

// ===== sv/vtpd_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Depends on vtpd_pkg. Quotient = trunc(s*2^F / w), saturated to 32 bits.
module vtpd_div #(
   parameter int FRAC_BITS = vtpd_pkg::DefFracBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [31:0]   in_num,
   input  logic signed [31:0]   in_den,
   output logic                 out_valid,
   output logic signed [31:0]   out_quot
);
   import vtpd_pkg::*;
   localparam int NW = 32 + FRAC_BITS;   // dividend magnitude width
   localparam int QW = NW;               // quotient bits

   logic [NW:0]     valid_ff, valid_in;
   logic [NW-1:0]   rem_ff [0:NW];
   logic [NW-1:0]   num_ff [0:NW];
   logic [31:0]     den_ff [0:NW];
   logic [QW-1:0]   quo_ff [0:NW];
   logic            neg_ff [0:NW];

   logic [31:0] mag_num, mag_den;
   assign mag_num = in_num[31] ? 32'(-in_num) : in_num;
   assign mag_den = in_den[31] ? 32'(-in_den) : in_den;

   always_comb begin
      valid_in = {valid_ff[NW-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      num_ff[0] <= {mag_num, {FRAC_BITS{1'b0}}};
      den_ff[0] <= mag_den;
      quo_ff[0] <= '0;
      neg_ff[0] <= in_num[31] ^ in_den[31];
   end

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [NW:0] trial;
      logic [NW:0] sub;
      assign trial = {rem_ff[i], num_ff[i][NW-1]};
      assign sub = trial - {{(NW-31){1'b0}}, den_ff[i]};
      always_ff @(posedge clock) begin
         if (!sub[NW]) rem_ff[i+1] <= sub[NW-1:0];
         else rem_ff[i+1] <= trial[NW-1:0];
         quo_ff[i+1] <= {quo_ff[i][QW-2:0], ~sub[NW]};
         num_ff[i+1] <= {num_ff[i][NW-2:0], 1'b0};
         den_ff[i+1] <= den_ff[i];
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   logic signed [QW+1:0] sq;
   logic signed [31:0]   q_in;
   logic                 v_ff;
   logic signed [31:0]   q_ff;
   always_comb begin
      sq = neg_ff[NW] ? -$signed({2'b00, quo_ff[NW]}) : $signed({2'b00, quo_ff[NW]});
      if (sq > $signed((QW+2)'(32'h7FFFFFFF))) q_in = 32'sh7FFFFFFF;
      else if (sq < -$signed((QW+2)'(33'h080000000))) q_in = -32'sh80000000;
      else q_in = sq[31:0];
   end
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= valid_ff[NW];
      q_ff <= q_in;
   end
   assign out_valid = v_ff;
   assign out_quot = q_ff;
endmodule

// ===== sv/vtpd_xform.sv =====
// Matrix stage: three pipeline stages of product, floor shift with partial sums,
// and final column sum with saturation. Depends on vtpd_pkg. Outputs s0..s3.
module vtpd_xform #(
   parameter int FRAC_BITS = vtpd_pkg::DefFracBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [31:0]   in_p [0:2],
   input  logic [63:0]          in_regs [0:7],
   output logic                 out_valid,
   output logic signed [31:0]   out_s [0:3]
);
   import vtpd_pkg::*;
   // A floored product needs 64-F bits; the sum of four terms needs two more.
   localparam int TermW = 64 - FRAC_BITS;
   localparam int AccW = TermW + 2;

   logic [2:0] valid_ff;
   logic signed [63:0] prod_ff [0:3][0:2];
   logic signed [31:0] trans_ff [0:3];
   logic signed [AccW-1:0] pair_a_ff [0:3];
   logic signed [AccW-1:0] pair_b_ff [0:3];
   logic signed [31:0] sum_ff [0:3];

   function automatic logic signed [31:0] coef(input logic [63:0] r [0:7],
                                               input int row, input int col);
      logic [63:0] w;
      begin
         w = r[row*2 + col/2];
         return (col % 2 == 1) ? $signed(w[63:32]) : $signed(w[31:0]);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[1:0], in_valid};
   end

   for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [AccW-1:0] acc;
      logic signed [31:0]     sat_in;
      always_ff @(posedge clock) begin
         trans_ff[c] <= coef(in_regs, 3, c);
      end
      for (genvar k = 0; k < 3; k++) begin : g_term
         always_ff @(posedge clock) begin
            prod_ff[c][k] <= 64'(in_p[k] * coef(in_regs, k, c));
         end
      end
      // Bits 63..F of a product are its floor after division by 2^F.
      always_ff @(posedge clock) begin
         pair_a_ff[c] <= AccW'($signed(prod_ff[c][0][63:FRAC_BITS]))
                       + AccW'($signed(prod_ff[c][1][63:FRAC_BITS]));
         pair_b_ff[c] <= AccW'($signed(prod_ff[c][2][63:FRAC_BITS]))
                       + AccW'(trans_ff[c]);
      end
      always_comb begin
         acc = pair_a_ff[c] + pair_b_ff[c];
         if (acc[AccW-1:31] == '0 || acc[AccW-1:31] == '1) sat_in = acc[31:0];
         else if (acc[AccW-1]) sat_in = 32'sh80000000;
         else sat_in = 32'sh7FFFFFFF;
      end
      always_ff @(posedge clock) sum_ff[c] <= sat_in;
      assign out_s[c] = sum_ff[c];
   end

   assign out_valid = valid_ff[2];
endmodule

// ===== sv/vertex_transform_perspective_divide.sv =====
// Top level of the vertex transform with perspective divide.
// Depends on vtpd_pkg, vtpd_xform and vtpd_div.
//
// One point enters per clock (busy is never high), and its result appears on
// rsp_valid after the matrix multiply and sum, then the bit-per-stage divider.
// The receiver cannot stall, so every result is shown for exactly one cycle.
// When w is zero the undivided sums are passed with rsp_w_was_zero set.
module vertex_transform_perspective_divide #(
   parameter int FRAC_BITS = vtpd_pkg::DefFracBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_in_x,
   input  logic signed [31:0]   req_in_y,
   input  logic signed [31:0]   req_in_z,
   input  logic                 csr_we,
   input  logic [vtpd_pkg::CsrAddrWidth-1:0] csr_index,
   input  logic [vtpd_pkg::CsrWidth-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic                 rsp_w_was_zero
);
   import vtpd_pkg::*;
   localparam logic [63:0] One = 64'(1) << FRAC_BITS;
   localparam int DivLat = 32 + FRAC_BITS + 2;

   logic [63:0] regs_ff [0:7];
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_ROW0_COLS01] <= One;
         regs_ff[REG_ROW0_COLS23] <= '0;
         regs_ff[REG_ROW1_COLS01] <= One << 32;
         regs_ff[REG_ROW1_COLS23] <= '0;
         regs_ff[REG_ROW2_COLS01] <= '0;
         regs_ff[REG_ROW2_COLS23] <= One;
         regs_ff[REG_ROW3_COLS01] <= '0;
         regs_ff[REG_ROW3_COLS23] <= One << 32;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   logic signed [31:0] pts [0:2];
   assign pts[0] = req_in_x;
   assign pts[1] = req_in_y;
   assign pts[2] = req_in_z;

   logic               xf_valid;
   logic signed [31:0] sums [0:3];
   vtpd_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
      .clock(clock), .reset(reset), .in_valid(start), .in_p(pts),
      .in_regs(regs_ff), .out_valid(xf_valid), .out_s(sums)
   );

   // The three columns divide in parallel; w zero is replaced by one and
   // the raw sums travel alongside so the zero case can select them.
   logic signed [31:0] den;
   logic               wz;
   assign wz = (sums[3] == 32'sd0);
   assign den = wz ? 32'sd1 : sums[3];

   logic [2:0]         dv;
   logic signed [31:0] quot [0:2];
   for (genvar c = 0; c < 3; c++) begin : g_div
      vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock), .reset(reset), .in_valid(xf_valid), .in_num(sums[c]),
         .in_den(den), .out_valid(dv[c]), .out_quot(quot[c])
      );
   end

   // Delay line for the zero flag and raw sums, matched to the divider.
   logic               wz_ff  [0:DivLat-1];
   logic signed [31:0] raw_ff [0:DivLat-1][0:2];
   always_ff @(posedge clock) begin
      wz_ff[0] <= wz;
      for (int c = 0; c < 3; c++) raw_ff[0][c] <= sums[c];
      for (int i = 1; i < DivLat; i++) begin
         wz_ff[i] <= wz_ff[i-1];
         for (int c = 0; c < 3; c++) raw_ff[i][c] <= raw_ff[i-1][c];
      end
   end

   assign rsp_valid = dv[0];
   assign rsp_w_was_zero = wz_ff[DivLat-1];
   assign rsp_out_x = wz_ff[DivLat-1] ? raw_ff[DivLat-1][0] : quot[0];
   assign rsp_out_y = wz_ff[DivLat-1] ? raw_ff[DivLat-1][1] : quot[1];
   assign rsp_out_z = wz_ff[DivLat-1] ? raw_ff[DivLat-1][2] : quot[2];
endmodule
